FILE: hdl/rfd_pkg.sv
`timescale 1ns / 1ps

package rfd_pkg;

  // Frame geometry
  localparam int unsigned FRAME_LENGTH = 18;
  localparam int unsigned POS_W        = 5;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_LENGTH - 1);
  localparam logic [POS_W-1:0] POS_IDLE = POS_W'(FRAME_LENGTH);

  localparam logic [10:0] STICK_CENTRE = 11'd1024;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_STICK_DEADBAND = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SPIKE_LIMIT    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_STALE_LIMIT    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_DEBOUNCE = CFG_IDX_W'(3);

  localparam logic [9:0]  RST_STICK_DEADBAND = 10'd3;
  localparam logic [15:0] RST_SPIKE_LIMIT    = 16'd150;
  localparam logic [7:0]  RST_STALE_LIMIT    = 8'd50;
  localparam logic [7:0]  RST_PRESS_DEBOUNCE = 8'd6;

  typedef struct packed {
    logic [9:0]  stick_deadband;
    logic [15:0] spike_limit;
    logic [7:0]  stale_limit;
    logic [7:0]  press_debounce;
  } rfd_cfg_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_start;
  } rfd_in_t;

  typedef struct packed {
    logic [10:0]        stick_ch0;
    logic [10:0]        stick_ch1;
    logic [10:0]        stick_ch2;
    logic [10:0]        stick_ch3;
    logic [3:0]         switch_pair;
    logic signed [15:0] mouse_x;
    logic signed [15:0] mouse_y_filtered;
    logic signed [15:0] mouse_z;
    logic               left_pressed;
    logic [7:0]         right_press_raw;
    logic [15:0]        key_bits;
    logic [10:0]        dial_value;
  } rfd_out_t;

  // Whole frame, last byte taken straight from the input
  typedef logic [FRAME_LENGTH-1:0][7:0] rfd_frame_t;

  typedef struct packed {
    logic       fire;
    rfd_frame_t bytes;
  } rfd_frame_req_t;

endpackage

FILE: hdl/rfd_assembler.sv
`timescale 1ns / 1ps

module rfd_assembler
  import rfd_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  rfd_in_t        item,
  output rfd_frame_req_t frame
);

  logic [POS_W-1:0] position;
  logic [POS_W-1:0] position_next;
  logic [POS_W-1:0] pos_eff;
  logic [7:0]       store [FRAME_LENGTH-1];

  // A start flag restarts the frame at byte 0
  assign pos_eff = item.frame_start ? '0 : position;

  always_comb begin
    position_next = position;
    if (accept) begin
      if (pos_eff < POS_LAST) begin
        position_next = pos_eff + POS_W'(1);
      end else if (pos_eff == POS_LAST) begin
        position_next = POS_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= POS_IDLE;
    end else begin
      position <= position_next;
    end
  end

  // Byte buffer, no reset
  always_ff @(posedge clk) begin
    for (int i = 0; i < FRAME_LENGTH - 1; i++) begin
      if (accept && pos_eff == POS_W'(i)) begin
        store[i] <= item.frame_byte;
      end
    end
  end

  // Frame out on the final byte
  always_comb begin
    frame.fire = accept && (pos_eff == POS_LAST);
    for (int i = 0; i < FRAME_LENGTH - 1; i++) begin
      frame.bytes[i] = store[i];
    end
    frame.bytes[FRAME_LENGTH-1] = item.frame_byte;
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    position <= POS_IDLE)
    else $error("byte position out of range");

  a_idle_after_fire: assert property (@(posedge clk) disable iff (rst)
    frame.fire |=> position == POS_IDLE)
    else $error("position not idle after a complete frame");

endmodule

FILE: hdl/rfd_decode.sv
`timescale 1ns / 1ps

module rfd_decode
  import rfd_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  rfd_cfg_t       cfg,
  input  rfd_frame_req_t frame,
  output rfd_out_t       result
);

  logic [15:0] previous_mouse_y;
  logic [15:0] previous_mouse_y_next;
  logic [8:0]  repeat_count;
  logic [8:0]  repeat_count_next;
  logic [7:0]  hold_count;
  logic [7:0]  hold_count_next;

  logic [10:0] ch0, ch1, ch2, ch3;
  logic [15:0] y_raw;
  logic [16:0] diff;
  logic [16:0] adiff;
  logic [15:0] y_spike;
  logic        rep_inc;
  logic [8:0]  rep_sum;
  rfd_frame_t  s;

  function automatic logic [10:0] dead(input logic [10:0] ch, input logic [9:0] band);
    logic [10:0] d;
    d = (ch >= STICK_CENTRE) ? (ch - STICK_CENTRE) : (STICK_CENTRE - ch);
    return (d > {1'b0, band}) ? ch : STICK_CENTRE;
  endfunction

  assign s = frame.bytes;

  // Stick channel unpacking
  assign ch0 = {s[1][2:0], s[0]};
  assign ch1 = {s[2][5:0], s[1][7:3]};
  assign ch2 = {s[4][0], s[3], s[2][7:6]};
  assign ch3 = {s[5][3:0], s[4][7:1]};

  // Mouse y spike filter, then stale count
  always_comb begin
    y_raw   = {s[9], s[8]};
    diff    = {y_raw[15], y_raw} - {previous_mouse_y[15], previous_mouse_y};
    adiff   = diff[16] ? (~diff + 17'd1) : diff;
    y_spike = (adiff > {1'b0, cfg.spike_limit}) ? previous_mouse_y : y_raw;
    rep_inc = (y_spike == previous_mouse_y) && (y_spike != 16'd0);
    rep_sum = repeat_count + {8'd0, rep_inc};
    if (rep_sum > {1'b0, cfg.stale_limit}) begin
      repeat_count_next     = '0;
      previous_mouse_y_next = '0;
    end else begin
      repeat_count_next     = rep_sum;
      previous_mouse_y_next = y_spike;
    end
  end

  // Left button hold, saturating
  always_comb begin
    if (s[12] == 8'd1) begin
      hold_count_next = (hold_count == 8'hff) ? hold_count : hold_count + 8'd1;
    end else begin
      hold_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_mouse_y <= '0;
      repeat_count     <= '0;
      hold_count       <= '0;
    end else if (frame.fire) begin
      previous_mouse_y <= previous_mouse_y_next;
      repeat_count     <= repeat_count_next;
      hold_count       <= hold_count_next;
    end
  end

  // Result assembly
  always_comb begin
    result.stick_ch0        = dead(ch0, cfg.stick_deadband);
    result.stick_ch1        = dead(ch1, cfg.stick_deadband);
    result.stick_ch2        = dead(ch2, cfg.stick_deadband);
    result.stick_ch3        = dead(ch3, cfg.stick_deadband);
    result.switch_pair      = s[5][7:4];
    result.mouse_x          = {s[7], s[6]};
    result.mouse_y_filtered = previous_mouse_y_next;
    result.mouse_z          = {s[11], s[10]};
    result.left_pressed     = hold_count_next > cfg.press_debounce;
    result.right_press_raw  = s[13];
    result.key_bits         = {s[15], s[14]};
    result.dial_value       = {s[17][2:0], s[16]};
  end

  a_repeat_bound: assert property (@(posedge clk) disable iff (rst)
    repeat_count <= 9'd256)
    else $error("repeat count beyond bound");

endmodule

FILE: hdl/remote_frame_decoder_filter.sv
`timescale 1ns / 1ps

// Remote-control frame decoder with mouse y and left button filtering.
//
// Input channel (in_valid/in_ready/in_item): one receiver byte per request,
// frame_start marks byte 0. Bytes without a preceding start are dropped;
// a start mid-frame abandons the partial frame.
// Output channel (out_valid/out_ready/out_item): one decoded frame per
// complete 18-byte frame, registered; it appears the cycle after the
// final byte is accepted.
// Throughput: one byte per cycle. The only stall source is the output
// register: while it holds an untaken result, in_ready follows out_ready.
// Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready;
// indices 0..3 select deadband, spike limit, stale limit and press
// debounce. Other indices are ignored. Write only while idle.
// Reset (rst, synchronous): registers take their default values, the
// decoder waits for a start flag, filter history and counts clear.
module remote_frame_decoder_filter
  import rfd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rfd_in_t               in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output rfd_out_t              out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  rfd_cfg_t       cfg_regs;
  rfd_frame_req_t frame;
  rfd_out_t       result;
  logic           in_accept;
  logic           out_free;

  assign out_free  = !out_valid || out_ready;
  assign in_ready  = out_free;
  assign in_accept = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.stick_deadband <= RST_STICK_DEADBAND;
      cfg_regs.spike_limit    <= RST_SPIKE_LIMIT;
      cfg_regs.stale_limit    <= RST_STALE_LIMIT;
      cfg_regs.press_debounce <= RST_PRESS_DEBOUNCE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_STICK_DEADBAND: cfg_regs.stick_deadband <= cfg_data[9:0];
        CFG_SPIKE_LIMIT:    cfg_regs.spike_limit    <= cfg_data[15:0];
        CFG_STALE_LIMIT:    cfg_regs.stale_limit    <= cfg_data[7:0];
        CFG_PRESS_DEBOUNCE: cfg_regs.press_debounce <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  rfd_assembler u_assembler (
    .clk    (clk),
    .rst    (rst),
    .accept (in_accept),
    .item   (in_item),
    .frame  (frame)
  );

  rfd_decode u_decode (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_regs),
    .frame  (frame),
    .result (result)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (frame.fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame.fire) begin
      out_item <= result;
    end
  end

  a_fire_has_room: assert property (@(posedge clk) disable iff (rst)
    frame.fire |-> out_free)
    else $error("frame completed with output register occupied");

  a_fire_shows: assert property (@(posedge clk) disable iff (rst)
    frame.fire |=> out_valid)
    else $error("completed frame not presented");

  a_fire_needs_input: assert property (@(posedge clk) disable iff (rst)
    frame.fire |-> in_valid && in_ready)
    else $error("frame completed without an accepted byte");

endmodule
